/* rtl/core/btk_pkg.sv */
// Shared constants, types and helpers of the bounded sorted top-k list.
package btk_pkg;

  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int SCORE_BITS  = 32;
  localparam int LIMIT_BITS  = 5;
  localparam int LIMIT_RESET = 16;

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  localparam int IN_DATA_BITS   = ((SCORE_BITS + HANDLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * HANDLE_BITS + SCORE_BITS + CNT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic signed [SCORE_BITS-1:0] score_t;
  typedef logic [HANDLE_BITS-1:0]       handle_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [LIMIT_BITS-1:0]        limit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear;
    logic shift;
    logic place_below;
    logic place_top;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic empty;
    logic shift_req;
    logic at_top;
  } status_t;

  typedef struct packed {
    logic    best_valid;
    handle_t best_handle;
    score_t  best_score;
    cnt_t    entry_count;
    logic    evicted_valid;
    handle_t evicted_handle;
  } result_t;

  // A limit of zero acts as one, anything above the capacity as the capacity.
  function automatic cnt_t eff_limit(limit_t lim);
    cnt_t r;
    if (lim == '0) begin
      r = cnt_t'(1);
    end else if (int'(lim) > CAPACITY) begin
      r = cnt_t'(CAPACITY);
    end else begin
      r = cnt_t'(lim);
    end
    return r;
  endfunction

endpackage

/* rtl/core/btk_datapath.sv */
// Datapath of the top-k list: entry memory, count, limit and result registers.
module btk_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  btk_pkg::limit_t   cfg_data,
  input  logic              in_func,
  input  btk_pkg::score_t   in_score,
  input  btk_pkg::handle_t  in_handle,
  input  btk_pkg::cmd_t     cmd,
  output btk_pkg::status_t  status,
  output btk_pkg::result_t  result
);

  btk_pkg::score_t  mem_score  [btk_pkg::CAPACITY];
  btk_pkg::handle_t mem_handle [btk_pkg::CAPACITY];

  btk_pkg::cnt_t    count;
  btk_pkg::limit_t  limit;
  logic             func_r;
  btk_pkg::score_t  score_r;
  btk_pkg::handle_t handle_r;
  btk_pkg::idx_t    idx;
  logic             first;
  logic             drop;
  btk_pkg::score_t  rd_score;
  btk_pkg::handle_t rd_handle;
  btk_pkg::score_t  best_score;
  btk_pkg::handle_t best_handle;
  logic             ev_valid;
  btk_pkg::handle_t ev_handle;

  btk_pkg::idx_t    rd_addr;
  logic             wr_en;
  btk_pkg::idx_t    wr_addr;
  btk_pkg::score_t  wr_score;
  btk_pkg::handle_t wr_handle;
  logic             evict_now;
  btk_pkg::cnt_t    count_grown;

  // The worst entry, held or new, falls out when the list is already at its limit.
  assign evict_now   = first && drop;
  assign count_grown = drop ? count : count + btk_pkg::cnt_t'(1);

  assign rd_addr = cmd.capture ? btk_pkg::idx_t'(count - btk_pkg::cnt_t'(1))
                               : idx - btk_pkg::idx_t'(1);

  assign status.is_clear  = func_r;
  assign status.empty     = (count == '0);
  assign status.shift_req = (rd_score < score_r);
  assign status.at_top    = (idx == '0);

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = idx + btk_pkg::idx_t'(1);
    wr_score  = score_r;
    wr_handle = handle_r;
    priority if (cmd.shift) begin
      wr_en     = !evict_now;
      wr_score  = rd_score;
      wr_handle = rd_handle;
    end else if (cmd.place_below) begin
      wr_en = !evict_now;
    end else if (cmd.place_top) begin
      wr_en   = 1'b1;
      wr_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_score[wr_addr]  <= wr_score;
      mem_handle[wr_addr] <= wr_handle;
    end
    rd_score  <= mem_score[rd_addr];
    rd_handle <= mem_handle[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      limit    <= btk_pkg::limit_t'(btk_pkg::LIMIT_RESET);
      first    <= 1'b0;
      ev_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit <= cfg_data;
      end
      if (cmd.capture) begin
        func_r    <= in_func;
        score_r   <= in_score;
        handle_r  <= in_handle;
        idx       <= btk_pkg::idx_t'(count - btk_pkg::cnt_t'(1));
        first     <= 1'b1;
        drop      <= (count >= btk_pkg::eff_limit(limit));
        ev_valid  <= 1'b0;
        ev_handle <= '0;
      end
      if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.shift) begin
        idx   <= idx - btk_pkg::idx_t'(1);
        first <= 1'b0;
        if (evict_now) begin
          ev_valid  <= 1'b1;
          ev_handle <= rd_handle;
        end
      end
      if (cmd.place_below) begin
        count <= count_grown;
        if (evict_now) begin
          ev_valid  <= 1'b1;
          ev_handle <= handle_r;
        end
      end
      if (cmd.place_top) begin
        count       <= count_grown;
        best_score  <= score_r;
        best_handle <= handle_r;
      end
      if (cmd.emit) begin
        result.best_valid     <= (count != '0);
        result.best_handle    <= (count != '0) ? best_handle : '0;
        result.best_score     <= (count != '0) ? best_score : '0;
        result.entry_count    <= count;
        result.evicted_valid  <= ev_valid;
        result.evicted_handle <= ev_valid ? ev_handle : '0;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    int'(count) <= btk_pkg::CAPACITY)
    else $error("entry count above capacity");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == '0) || (count == $past(count)) ||
             (count == $past(count) + btk_pkg::cnt_t'(1)))
    else $error("entry count moved by more than one");

  a_evict_on_shift : assert property (@(posedge clk) disable iff (rst)
    cmd.shift && first && drop |=> ev_valid && !first)
    else $error("worst entry shifted out without being reported");

endmodule

/* rtl/core/btk_ctrl.sv */
// Controller of the top-k list: sequences capture, scan, insert and result hand-off.
module btk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  btk_pkg::status_t  status,
  output btk_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_TOP,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        // Walk up from the worst entry, moving down every entry the new one beats.
        priority if (status.is_clear) begin
          cmd.clear  = 1'b1;
          state_next = ST_FINISH;
        end else if (status.empty) begin
          state_next = ST_TOP;
        end else if (status.shift_req && !status.at_top) begin
          cmd.shift = 1'b1;
        end else if (status.shift_req) begin
          cmd.shift  = 1'b1;
          state_next = ST_TOP;
        end else begin
          cmd.place_below = 1'b1;
          state_next      = ST_FINISH;
        end
      end
      ST_TOP: begin
        cmd.place_top = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.emit = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_one_cmd : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.clear, cmd.shift, cmd.place_below, cmd.place_top, cmd.emit}))
    else $error("more than one datapath command at once");

  a_emit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before it was taken");

  a_no_back_to_back : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new transaction taken while one is in progress");

endmodule

/* rtl/core/bounded_sorted_topk_list.sv */
// Top level of the bounded sorted top-k list.
//
// Keeps up to list_limit (score, handle) entries ordered best first; equal
// scores stay in arrival order. A transaction on the s_ channel either adds an
// entry (tuser = 0) or clears the list (tuser = 1). Each input transaction
// yields exactly one result transaction on the m_ channel: best entry, count
// and the handle of any entry pushed out by an add.
// The cfg channel writes list_limit; it is always ready and should be used
// only while the block is idle. A limit of 0 acts as 1, above 16 as 16.
// Timing: an add walks the entry memory from the worst entry upwards, one
// entry per cycle through its single read port; a new entry that beats
// every held one, or that enters an empty list, is then written at the top
// by a separate state.
// The result is held in an output register, so the next input transaction is
// accepted while a result still waits; a stalled receiver only holds up the
// item after that. Reset empties the list, sets the limit to 16 and drops any
// pending result. No clearing pass is needed after reset.
module bounded_sorted_topk_list (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: score, handle (from bit 0 up)
  input  logic [btk_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // s_tuser: func (0 = add, 1 = clear)
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: best_handle, best_score, entry_count, evicted_handle (from bit 0 up)
  output logic [btk_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // m_tuser: best_valid, evicted_valid (from bit 0 up)
  output logic [1:0]                          m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [btk_pkg::LIMIT_BITS-1:0]      cfg_data
);

  btk_pkg::cmd_t    cmd;
  btk_pkg::status_t status;
  btk_pkg::result_t result;

  assign cfg_ready = 1'b1;

  btk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  btk_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_func   (s_tuser[0]),
    .in_score  (s_tdata[btk_pkg::SCORE_BITS-1:0]),
    .in_handle (s_tdata[btk_pkg::SCORE_BITS +: btk_pkg::HANDLE_BITS]),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign m_tdata = btk_pkg::OUT_DATA_BITS'({result.evicted_handle, result.entry_count,
                                            result.best_score, result.best_handle});
  assign m_tuser = {result.evicted_valid, result.best_valid};

endmodule

/* bench/bounded_sorted_topk_list_tb.sv */
// Self-checking testbench for the bounded sorted top-k list, with scoreboard and drivers.
`timescale 1ns / 1ps

module bounded_sorted_topk_list_tb;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 40;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 120;

  localparam bit FUNC_ADD   = 1'b0;
  localparam bit FUNC_CLEAR = 1'b1;

  // Tracks the expected list contents and the summaries that the block owes us.
  class topk_list_checker;
    btk_pkg::score_t  ranked_scores[$];
    btk_pkg::handle_t ranked_handles[$];
    btk_pkg::limit_t  limit_reg;
    btk_pkg::result_t pending_summaries[$];
    int               errors;
    int               checked;
    int               evictions;

    function new();
      limit_reg = btk_pkg::limit_t'(btk_pkg::LIMIT_RESET);
      errors    = 0;
      checked   = 0;
      evictions = 0;
    endfunction

    function void set_limit(btk_pkg::limit_t v);
      limit_reg = v;
    endfunction

    function int pending_count();
      return pending_summaries.size();
    endfunction

    // Works out the summary that one accepted input transaction must produce.
    function void note_item(bit func, btk_pkg::score_t sc, btk_pkg::handle_t hd);
      btk_pkg::result_t r;
      int               pos;
      int               keep;
      r = '0;
      if (func == FUNC_CLEAR) begin
        ranked_scores.delete();
        ranked_handles.delete();
      end else begin
        if (limit_reg == '0) keep = 1;
        else if (int'(limit_reg) > btk_pkg::CAPACITY) keep = btk_pkg::CAPACITY;
        else keep = int'(limit_reg);
        pos = 0;
        // Equal scores stay in arrival order, so the newcomer goes after them.
        while (pos < ranked_scores.size() && ranked_scores[pos] >= sc) pos++;
        ranked_scores.insert(pos, sc);
        ranked_handles.insert(pos, hd);
        if (ranked_scores.size() > keep) begin
          r.evicted_valid  = 1'b1;
          r.evicted_handle = ranked_handles[$];
          void'(ranked_scores.pop_back());
          void'(ranked_handles.pop_back());
        end
      end
      if (ranked_scores.size() > 0) begin
        r.best_valid  = 1'b1;
        r.best_handle = ranked_handles[0];
        r.best_score  = ranked_scores[0];
      end
      r.entry_count = btk_pkg::cnt_t'(ranked_scores.size());
      pending_summaries.push_back(r);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_result(btk_pkg::result_t got);
      btk_pkg::result_t want;
      if (pending_summaries.size() == 0) begin
        report("result transaction arrived with nothing expected");
      end else begin
        want = pending_summaries.pop_front();
        checked++;
        if (got.evicted_valid === 1'b1) evictions++;
        if (got.best_valid !== want.best_valid)
          report($sformatf("best_valid got %b want %b", got.best_valid, want.best_valid));
        if (got.best_handle !== want.best_handle)
          report($sformatf("best_handle got %h want %h", got.best_handle, want.best_handle));
        if (got.best_score !== want.best_score)
          report($sformatf("best_score got %h want %h", got.best_score, want.best_score));
        if (got.entry_count !== want.entry_count)
          report($sformatf("entry_count got %0d want %0d", got.entry_count, want.entry_count));
        if (got.evicted_valid !== want.evicted_valid)
          report($sformatf("evicted_valid got %b want %b", got.evicted_valid,
                           want.evicted_valid));
        if (got.evicted_handle !== want.evicted_handle)
          report($sformatf("evicted_handle got %h want %h", got.evicted_handle,
                           want.evicted_handle));
      end
    endtask
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [btk_pkg::IN_DATA_BITS-1:0]   s_tdata = '0;
  logic [0:0]                         s_tuser = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [btk_pkg::OUT_DATA_BITS-1:0]  m_tdata;
  logic [1:0]                         m_tuser;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [btk_pkg::LIMIT_BITS-1:0]     cfg_data = '0;

  topk_list_checker list_chk = new();
  int  items_sent    = 0;
  int  burst_left    = 0;
  int  limit_writes  = 0;
  int  cycle_count   = 0;
  bit  long_hold_done = 1'b0;

  bounded_sorted_topk_list u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               list_chk.pending_count());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result monitor: every result transaction is unpacked and checked.
  always @(posedge clk) begin
    btk_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.best_handle    = m_tdata[btk_pkg::HANDLE_BITS-1:0];
      got.best_score     = m_tdata[btk_pkg::HANDLE_BITS +: btk_pkg::SCORE_BITS];
      got.entry_count    = m_tdata[btk_pkg::HANDLE_BITS+btk_pkg::SCORE_BITS +:
                                   btk_pkg::CNT_BITS];
      got.evicted_handle = m_tdata[btk_pkg::HANDLE_BITS+btk_pkg::SCORE_BITS+btk_pkg::CNT_BITS +:
                                   btk_pkg::HANDLE_BITS];
      got.best_valid     = m_tuser[0];
      got.evicted_valid  = m_tuser[1];
      list_chk.check_result(got);
    end
  end

  // Receiver: runs of steady ready, short stalls and random toggling, plus one long hold.
  initial begin
    int mode;
    int run;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (items_sent >= HOLD_AFTER && !long_hold_done) begin
        long_hold_done = 1'b1;
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      run  = (mode == 1) ? $urandom_range(1, 8) : $urandom_range(1, 30);
      repeat (run) begin
        case (mode)
          0: begin
            m_tready = 1'b1;
          end
          1: begin
            m_tready = 1'b0;
          end
          default: begin
            m_tready = 1'($urandom_range(0, 1));
          end
        endcase
        @(negedge clk);
      end
    end
  end

  // Offers one item and waits for its transaction; gaps follow at the end of a burst.
  task automatic push_item(bit func, btk_pkg::score_t sc, btk_pkg::handle_t hd);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {hd, sc};
    s_tuser  = func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    list_chk.note_item(func, sc, hd);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata  = btk_pkg::IN_DATA_BITS'({$urandom, $urandom});
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (list_chk.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(btk_pkg::limit_t v);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    list_chk.set_limit(v);
    limit_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Four times in ten a narrow set of scores so ties are common, otherwise the full range.
  function automatic btk_pkg::score_t pick_score();
    btk_pkg::score_t picks[7];
    picks = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh1, -32'sh1,
              32'sh0001_0000, -32'sh0001_0000};
    if ($urandom_range(0, 9) < 4) return picks[$urandom_range(0, 6)];
    return btk_pkg::score_t'($urandom);
  endfunction

  initial begin
    btk_pkg::limit_t phase_limits[10];
    bit              func;
    phase_limits = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd16, 5'd7, 5'd17, 5'd4, 5'd16, 5'd10};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, ties, clears and the reset limit.
    push_item(FUNC_CLEAR, 32'sh0, 16'h0);
    push_item(FUNC_ADD, 32'sh0, 16'h0000);
    push_item(FUNC_ADD, 32'sh0, 16'hFFFF);
    push_item(FUNC_ADD, 32'sh7FFF_FFFF, 16'h1234);
    push_item(FUNC_ADD, 32'sh8000_0000, 16'h4321);
    push_item(FUNC_ADD, 32'sh7FFF_FFFF, 16'h0AAA);
    push_item(FUNC_ADD, -32'sh1, 16'h5555);
    push_item(FUNC_ADD, 32'sh1, 16'hA5A5);
    // Limit lowered under the count: the count must hold steady, not shrink.
    write_limit(5'd3);
    push_item(FUNC_ADD, 32'sh0001_0000, 16'h0F0F);
    push_item(FUNC_ADD, 32'sh8000_0000, 16'hBEEF);
    push_item(FUNC_CLEAR, 32'sh7FFF_FFFF, 16'hFFFF);
    push_item(FUNC_CLEAR, 32'sh0, 16'h0);
    write_limit(5'd1);
    push_item(FUNC_ADD, -32'sh5, 16'h0001);
    push_item(FUNC_ADD, 32'sh3, 16'h0002);
    push_item(FUNC_ADD, 32'sh3, 16'h0003);
    push_item(FUNC_ADD, 32'sh8000_0000, 16'h0004);
    write_limit(5'd0);
    push_item(FUNC_ADD, 32'sh7FFF_FFFF, 16'hFFFF);
    push_item(FUNC_ADD, 32'sh7FFF_FFFF, 16'h0000);

    // Random phases; clears are rare so the list fills and a lowered limit finds it full.
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      repeat (PHASE_ITEMS) begin
        func = ($urandom_range(0, 29) == 0) ? FUNC_CLEAR : FUNC_ADD;
        push_item(func, pick_score(), btk_pkg::handle_t'($urandom_range(0, 65535)));
      end
    end

    drain_results();
    $display("Sent %0d input transactions and checked %0d results, %0d with an eviction.",
             items_sent, list_chk.checked, list_chk.evictions);
    $display("The limit was written %0d times, from 0 up to 31, and lowered under a full list.",
             limit_writes);
    if (list_chk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
